FILE: hdl/vbf_pkg.sv
// ----------------------------------------------------------------------------
// vbf_pkg
// Shared widths, register indexes and command codes of the 3x3x3 volume box
// filter.
// ----------------------------------------------------------------------------
package vbf_pkg;

  localparam int MAX_DIM_DEFAULT     = 16;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  localparam int DIM_W      = 5;   // dimension register width
  localparam int POS_W      = 4;   // query coordinate width
  localparam int CNT_W      = 5;   // neighbour count width (1..27)
  localparam int SUM_GROW   = 5;   // guard bits for a sum of 27 samples
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

FILE: hdl/vbf_in_if.sv
// ----------------------------------------------------------------------------
// vbf_in_if
// Input channel of the volume box filter: load and query beats.
// ----------------------------------------------------------------------------
interface vbf_in_if #(
  parameter int SAMPLE_BITS = vbf_pkg::SAMPLE_BITS_DEFAULT
);
  logic                            valid;
  logic                            ready;
  logic                            cmd;
  logic signed [SAMPLE_BITS-1:0]   sample;
  logic [vbf_pkg::POS_W-1:0]       pos_x;
  logic [vbf_pkg::POS_W-1:0]       pos_y;
  logic [vbf_pkg::POS_W-1:0]       pos_z;

  modport source (output valid, cmd, sample, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, cmd, sample, pos_x, pos_y, pos_z, output ready);
endinterface

FILE: hdl/vbf_out_if.sv
// ----------------------------------------------------------------------------
// vbf_out_if
// Result channel of the volume box filter: one beat per query.
// ----------------------------------------------------------------------------
interface vbf_out_if #(
  parameter int SAMPLE_BITS = vbf_pkg::SAMPLE_BITS_DEFAULT
);
  logic                            valid;
  logic                            ready;
  logic signed [SAMPLE_BITS-1:0]   smoothed;
  logic [vbf_pkg::CNT_W-1:0]       neighbour_count;

  modport source (output valid, smoothed, neighbour_count, input ready);
  modport sink   (input valid, smoothed, neighbour_count, output ready);
endinterface

FILE: hdl/vbf_vol_mem.sv
// ----------------------------------------------------------------------------
// vbf_vol_mem
// Single-port sample memory, registered read data.
// ----------------------------------------------------------------------------
module vbf_vol_mem #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/vbf_divider.sv
// ----------------------------------------------------------------------------
// vbf_divider
// Restoring unsigned divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module vbf_divider #(
  parameter int DIVIDEND_W = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DIVIDEND_W-1:0]      dividend,
  input  logic [vbf_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);
  import vbf_pkg::*;

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              fits;

  // shift the next dividend bit into the partial remainder
  assign trial     = {rem, quotient[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, div_r};
  assign fits      = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      div_r    <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

FILE: hdl/volume_box_filter_3x3x3_core.sv
// ----------------------------------------------------------------------------
// volume_box_filter_3x3x3_core
// Stores a sample volume loaded in raster order and answers queries with the
// mean of the in-grid 3x3x3 neighbourhood of a voxel and the neighbour count.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+---------------------------------------
//  items     | in  | valid / ready  | cmd, sample, pos_x, pos_y, pos_z
//  results   | out | valid / ready  | smoothed, neighbour_count
//  cfg       | in  | cfg_we         | cfg_index (0 dim_x, 1 dim_y, 2 dim_z)
//
//  A load beat forms the volume size from the dimension registers, then
//  writes the sample at the load pointer. A query beat makes 27 reads of
//  the single memory port (one neighbour per cycle) and then the bit-serial
//  divide, one quotient bit per cycle over SAMPLE_BITS + 4 bits.
//  Synchronous reset clears control, the load pointer and the dimensions
//  (all 9); the volume memory is not cleared and holds nothing meaningful
//  until loaded. A result waiting on a stalled results channel sits in the
//  output register while the next beat is accepted; a finished query holds
//  until the output register is free.
//
module volume_box_filter_3x3x3_core #(
  parameter int MAX_DIM     = vbf_pkg::MAX_DIM_DEFAULT,
  parameter int SAMPLE_BITS = vbf_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [vbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbf_pkg::CFG_DATA_W-1:0] cfg_data,
  vbf_in_if.sink                         items,
  vbf_out_if.source                      results
);
  import vbf_pkg::*;

  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SUM_W       = SAMPLE_BITS + SUM_GROW;
  localparam int MAG_W       = SUM_W - 1;
  localparam int PROD_W      = 2 * DIM_W;
  localparam int TOT_W       = 3 * DIM_W;
  localparam int CMP_W       = (ADDR_W + 1 > TOT_W) ? ADDR_W + 1 : TOT_W;

  localparam logic [1:0] OFS_LAST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_SIZE,
    S_LD_WRITE,
    S_Q_MUL,
    S_Q_INIT,
    S_Q_RUN,
    S_Q_LAST,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  state_t state;

  // --------------------------------------------------------------------------
  // Dimension registers and derived sizes
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]  dim_x, dim_y, dim_z;
  logic [DIM_W-1:0]  dx, dy, dz;
  logic [PROD_W-1:0] dxy;
  logic [TOT_W-1:0]  total;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // saturate a query coordinate to the last grid point
  function automatic logic [DIM_W-1:0] clamp_pos(input logic [POS_W-1:0] p,
                                                 input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = DIM_W'(p);
    if (r >= d) begin
      r = d - DIM_W'(1);
    end
    return r;
  endfunction

  // neighbour at offset o (0..2 stands for -1..+1) lies inside the grid
  function automatic logic nbr_ok(input logic [DIM_W-1:0] p,
                                  input logic [1:0]       o,
                                  input logic [DIM_W-1:0] d);
    logic [DIM_W:0] p_up;
    logic           ok;
    p_up = {1'b0, p} + (DIM_W+1)'(1);
    ok   = 1'b1;
    if (o == 2'd0 && p == '0) begin
      ok = 1'b0;
    end
    if (o == OFS_LAST && p_up >= {1'b0, d}) begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_x <= DIM_RESET;
      dim_y <= DIM_RESET;
      dim_z <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIM_X: dim_x <= cfg_data;
        CFG_DIM_Y: dim_y <= cfg_data;
        CFG_DIM_Z: dim_z <= cfg_data;
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  assign dx = eff_dim(dim_x);
  assign dy = eff_dim(dim_y);
  assign dz = eff_dim(dim_z);

  // two registered multiplies; both settle before a load needs them
  always_ff @(posedge clk) begin
    dxy   <= PROD_W'(dx) * PROD_W'(dy);
    total <= TOT_W'(dxy) * TOT_W'(dz);
  end

  // --------------------------------------------------------------------------
  // Input beat
  // --------------------------------------------------------------------------
  logic accept;

  // hold ready low while in reset so that no beat looks taken
  assign items.ready = (state == S_IDLE) && !rst;
  assign accept      = items.valid && items.ready;

  // --------------------------------------------------------------------------
  // Load pointer
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]      ld_ptr;
  logic [ADDR_W-1:0]      ld_addr;
  logic [ADDR_W:0]        ld_next;
  logic [SAMPLE_BITS-1:0] ld_sample;

  // a pointer left beyond a shrunken volume restarts at zero
  assign ld_addr = (CMP_W'(ld_ptr) >= CMP_W'(total)) ? '0 : ld_ptr;
  assign ld_next = {1'b0, ld_addr} + (ADDR_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      ld_ptr <= '0;
    end else if (state == S_LD_WRITE) begin
      ld_ptr <= (CMP_W'(ld_next) >= CMP_W'(total)) ? '0 : ld_next[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_sample <= items.sample;
    end
  end

  // --------------------------------------------------------------------------
  // Neighbourhood walk: x fastest, then y, then z; one memory read per cycle.
  // Addresses are formed modulo 2^ADDR_W; out-of-grid reads are masked.
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]  px, py, pz;
  logic [1:0]        ox, oy, oz;
  logic [ADDR_W-1:0] ymul, zmul;
  logic [ADDR_W-1:0] yterm, zterm;
  logic [ADDR_W-1:0] rd_addr;
  logic              nbr_in;
  logic              walk_end;

  assign rd_addr  = ADDR_W'(px) + ADDR_W'(ox) - ADDR_W'(1) + yterm + zterm;
  assign nbr_in   = nbr_ok(px, ox, dx) && nbr_ok(py, oy, dy) && nbr_ok(pz, oz, dz);
  assign walk_end = (ox == OFS_LAST) && (oy == OFS_LAST) && (oz == OFS_LAST);

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= clamp_pos(items.pos_x, dx);
      py <= clamp_pos(items.pos_y, dy);
      pz <= clamp_pos(items.pos_z, dz);
    end
    case (state)
      S_Q_MUL: begin
        ymul <= ADDR_W'(PROD_W'(py) * PROD_W'(dx));
        zmul <= ADDR_W'(TOT_W'(pz) * TOT_W'(dxy));
      end
      S_Q_INIT: begin
        // start one row and one plane below the center
        yterm <= ymul - ADDR_W'(dx);
        zterm <= zmul - ADDR_W'(dxy);
        ox    <= '0;
        oy    <= '0;
        oz    <= '0;
      end
      S_Q_RUN: begin
        if (ox != OFS_LAST) begin
          ox <= ox + 2'd1;
        end else begin
          ox <= '0;
          if (oy != OFS_LAST) begin
            oy    <= oy + 2'd1;
            yterm <= yterm + ADDR_W'(dx);
          end else begin
            // rewind to the lowest row, advance one plane
            oy    <= '0;
            yterm <= yterm - (ADDR_W'(dx) << 1);
            oz    <= oz + 2'd1;
            zterm <= zterm + ADDR_W'(dxy);
          end
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Volume memory
  // --------------------------------------------------------------------------
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  logic [SAMPLE_BITS-1:0] mem_rdata;

  assign mem_we   = (state == S_LD_WRITE);
  assign mem_addr = mem_we ? ld_addr : rd_addr;

  vbf_vol_mem #(
    .DEPTH  (STORE_DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_vol_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (ld_sample),
    .rdata (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Accumulate: read data lands in the cycle after its address
  // --------------------------------------------------------------------------
  logic             rd_hit;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_hit <= 1'b0;
    end else begin
      rd_hit <= (state == S_Q_RUN) && nbr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_Q_INIT) begin
      sum <= '0;
      cnt <= '0;
    end else if (rd_hit) begin
      sum <= sum + {{SUM_GROW{mem_rdata[SAMPLE_BITS-1]}}, mem_rdata};
      cnt <= cnt + CNT_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Divide magnitude by count, restore the sign (truncation toward zero)
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0] sum_abs;
  logic             neg;
  logic             div_done;
  logic [MAG_W-1:0] quot;
  logic [MAG_W-1:0] mean;

  assign sum_abs = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
  assign mean    = neg ? (~quot + MAG_W'(1)) : quot;

  always_ff @(posedge clk) begin
    if (state == S_DIV_GO) begin
      neg <= sum[SUM_W-1];
    end
  end

  vbf_divider #(
    .DIVIDEND_W (MAG_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIV_GO),
    .dividend (sum_abs[MAG_W-1:0]),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quot)
  );

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  logic out_load;
  logic res_valid;

  assign out_load      = (state == S_OUT) && (!res_valid || results.ready);
  assign results.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (items.cmd == CMD_QUERY) ? S_Q_MUL : S_LD_SIZE;
          end
        end
        S_LD_SIZE:  state <= S_LD_WRITE;
        S_LD_WRITE: state <= S_IDLE;
        S_Q_MUL:    state <= S_Q_INIT;
        S_Q_INIT:   state <= S_Q_RUN;
        S_Q_RUN: begin
          if (walk_end) begin
            state <= S_Q_LAST;
          end
        end
        S_Q_LAST:   state <= S_DIV_GO;
        S_DIV_GO:   state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default:    state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.smoothed        <= mean[SAMPLE_BITS-1:0];
      results.neighbour_count <= cnt;
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3x3 volume box filter. A built-in model
// follows every accepted load and query beat and keeps the expected mean and
// neighbour count of each query in order. A checker compares every result
// beat against that queue.
// ----------------------------------------------------------------------------
module tb_top;
  import vbf_pkg::*;

  localparam int SAMPLE_W      = SAMPLE_BITS_DEFAULT;
  localparam int DIM_CAP       = MAX_DIM_DEFAULT;
  localparam int VOXELS        = DIM_CAP * DIM_CAP * DIM_CAP;
  // Wait this long once quiet so that a trailing load or query can finish.
  localparam int SETTLE_CYCLES = 64;
  // Give up after this many cycles in which no beat moves on either side.
  localparam int STALL_LIMIT   = 2000;
  localparam int IDLE_PCT      = 11;
  localparam int QUERY_PCT     = 55;
  localparam int RANDOM_BEATS  = 50;
  localparam int N_VOLUMES     = 11;
  localparam int STEADY_VOLUME = 4;

  // Index 3 maps to no register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Raw register values for each random volume. The list includes the
  // extremes 1 and 16 on each axis, 0 and values above 16 (which clamp),
  // and a few shrinks that reuse earlier samples without reloading.
  localparam logic [DIM_W-1:0] VOLUME_DIMS [N_VOLUMES][3] = '{
    '{5'd16, 5'd1,  5'd1 },
    '{5'd1,  5'd16, 5'd1 },
    '{5'd1,  5'd1,  5'd16},
    '{5'd31, 5'd0,  5'd2 },
    '{5'd3,  5'd3,  5'd3 },
    '{5'd5,  5'd4,  5'd3 },
    '{5'd2,  5'd2,  5'd2 },
    '{5'd16, 5'd4,  5'd1 },
    '{5'd7,  5'd2,  5'd5 },
    '{5'd4,  5'd4,  5'd4 },
    '{5'd2,  5'd17, 5'd2 }
  };

  typedef struct {
    logic signed [SAMPLE_W-1:0] smoothed;
    logic [CNT_W-1:0]           count;
  } mean_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  vbf_in_if  items ();
  vbf_out_if results ();

  volume_box_filter_3x3x3_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items),
    .results   (results)
  );

  // Model state: the stored volume, which entries hold a loaded sample,
  // the raster load pointer and the raw dimension registers.
  logic signed [SAMPLE_W-1:0] voxel_mem [VOXELS];
  bit                         voxel_loaded [VOXELS];
  int                         load_ptr;
  logic [DIM_W-1:0]           dim_reg [3];

  // Means of accepted queries, oldest first.
  mean_t pending_means [$];

  int mismatches;
  int results_seen;
  int quiet_cycles;
  // Set for one volume: both sides run with no idle cycles at all.
  bit steady;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // Register value in use: 0 acts as 1, anything above the grid as the grid.
  function automatic int span(input logic [DIM_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > DIM_CAP) return DIM_CAP;
    return int'(raw);
  endfunction

  function automatic int grid_voxels();
    return span(dim_reg[CFG_DIM_X]) * span(dim_reg[CFG_DIM_Y]) * span(dim_reg[CFG_DIM_Z]);
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DIM_X: dim_reg[CFG_DIM_X] = data;
      CFG_DIM_Y: dim_reg[CFG_DIM_Y] = data;
      CFG_DIM_Z: dim_reg[CFG_DIM_Z] = data;
      default: ;
    endcase
  endfunction

  // Advance the model by one accepted beat: store a load, or average the
  // neighbourhood of a query and queue the expected result.
  function automatic void filter_beat(input logic op,
                                      input logic signed [SAMPLE_W-1:0] sample,
                                      input logic [POS_W-1:0] px,
                                      input logic [POS_W-1:0] py,
                                      input logic [POS_W-1:0] pz);
    int    dx, dy, dz, total;
    int    cx, cy, cz;
    int    x, y, z, ox, oy, oz;
    int    sum, cnt;
    mean_t m;
    dx    = span(dim_reg[CFG_DIM_X]);
    dy    = span(dim_reg[CFG_DIM_Y]);
    dz    = span(dim_reg[CFG_DIM_Z]);
    total = dx * dy * dz;
    if (op == CMD_LOAD) begin
      // A pointer left beyond a shrunken volume restarts at zero.
      if (load_ptr >= total) load_ptr = 0;
      voxel_mem[load_ptr]    = sample;
      voxel_loaded[load_ptr] = 1'b1;
      load_ptr++;
      if (load_ptr >= total) load_ptr = 0;
    end else begin
      // Clamp coordinates outside the grid to its last plane.
      cx  = (int'(px) >= dx) ? dx - 1 : int'(px);
      cy  = (int'(py) >= dy) ? dy - 1 : int'(py);
      cz  = (int'(pz) >= dz) ? dz - 1 : int'(pz);
      sum = 0;
      cnt = 0;
      for (oz = -1; oz <= 1; oz++) begin
        for (oy = -1; oy <= 1; oy++) begin
          for (ox = -1; ox <= 1; ox++) begin
            x = cx + ox;
            y = cy + oy;
            z = cz + oz;
            if (x >= 0 && y >= 0 && z >= 0 && x < dx && y < dy && z < dz) begin
              sum += int'(voxel_mem[x + dx * (y + dy * z)]);
              cnt++;
            end
          end
        end
      end
      // Integer division truncates toward zero, as the block must.
      m.smoothed = SAMPLE_W'(sum / cnt);
      m.count    = CNT_W'(cnt);
      pending_means.insert(pending_means.size(), m);
    end
  endfunction

  // True once every voxel of the current grid holds a loaded sample.
  function automatic bit volume_filled();
    int total;
    total = grid_voxels();
    for (int i = 0; i < total; i++) begin
      if (!voxel_loaded[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    return SAMPLE_W'($urandom());
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom_range(0, 15));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one beat on the items channel; return at the edge that takes it.
  // Leave valid high so that a following beat goes out back to back.
  task automatic send_item(input logic op,
                           input logic signed [SAMPLE_W-1:0] sample,
                           input logic [POS_W-1:0] px,
                           input logic [POS_W-1:0] py,
                           input logic [POS_W-1:0] pz);
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      items.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    items.valid  <= 1'b1;
    items.cmd    <= op;
    items.sample <= sample;
    items.pos_x  <= px;
    items.pos_y  <= py;
    items.pos_z  <= pz;
    do @(posedge clk); while (!items.ready);
    filter_beat(op, sample, px, py, pz);
  endtask

  // Unused fields carry random bits so that the block must ignore them.
  task automatic load_sample(input logic signed [SAMPLE_W-1:0] sample);
    send_item(CMD_LOAD, sample, rand_pos(), rand_pos(), rand_pos());
  endtask

  task automatic query_voxel(input logic [POS_W-1:0] px,
                             input logic [POS_W-1:0] py,
                             input logic [POS_W-1:0] pz);
    send_item(CMD_QUERY, rand_sample(), px, py, pz);
  endtask

  // Write one register; the caller drops cfg_we after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_register(idx, data);
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] dx,
                          input logic [DIM_W-1:0] dy,
                          input logic [DIM_W-1:0] dz);
    write_reg(CFG_DIM_X, dx);
    write_reg(CFG_DIM_Y, dy);
    write_reg(CFG_DIM_Z, dz);
    cfg_we <= 1'b0;
  endtask

  // Drop valid, drain every expected result, then let a trailing load
  // finish before the registers may change.
  task automatic settle();
    items.valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Leave dim_z at its reset value and load a column along z, starting from
  // the reset load pointer. Samples span the full signed range.
  task automatic test_reset_state();
    write_reg(CFG_DIM_X, 5'd1);
    write_reg(CFG_DIM_Y, 5'd1);
    cfg_we <= 1'b0;
    load_sample(16'h7FFF);
    load_sample(16'h8000);
    load_sample(16'h0000);
    load_sample(16'hFFFF);
    load_sample(16'h0001);
    load_sample(16'h5555);
    load_sample(16'hAAAA);
    load_sample(16'h1000);
    load_sample(16'hF000);
    query_voxel(4'd0, 4'd0, 4'd0);
    query_voxel(4'd0, 4'd0, 4'd4);
    query_voxel(4'd0, 4'd0, 4'd8);
    // Coordinates past the grid clamp to the last voxel on each axis.
    query_voxel(4'd15, 4'd15, 4'd15);
    query_voxel(4'd3, 4'd7, 4'd11);
    settle();
  endtask

  // Two-voxel line: negative sums with a remainder must round toward zero,
  // and the load pointer wraps after every second load.
  task automatic test_truncation();
    set_dims(5'd2, 5'd1, 5'd1);
    load_sample(16'h7FFF);
    load_sample(16'h8000);
    query_voxel(4'd0, 4'd0, 4'd0);
    load_sample(16'h8000);
    load_sample(16'h8001);
    query_voxel(4'd1, 4'd0, 4'd0);
    load_sample(16'h8000);
    load_sample(16'h8000);
    query_voxel(4'd15, 4'd0, 4'd0);
    load_sample(16'h7FFF);
    load_sample(16'h7FFF);
    query_voxel(4'd0, 4'd15, 4'd15);
    settle();
  endtask

  // Zero dimensions act as one: a single voxel that averages only itself.
  // A write to the spare index must change nothing.
  task automatic test_degenerate_dims();
    write_reg(CFG_DIM_X, 5'd0);
    write_reg(CFG_DIM_Y, 5'd0);
    write_reg(CFG_DIM_Z, 5'd0);
    write_reg(CFG_SPARE, 5'd31);
    cfg_we <= 1'b0;
    load_sample(rand_sample());
    query_voxel(4'd15, 4'd15, 4'd15);
    load_sample(rand_sample());
    query_voxel(4'd0, 4'd0, 4'd0);
    settle();
  endtask

  // For each grid: fill whatever is not yet loaded, then mix queries at
  // random coordinates with loads that overwrite samples in raster order.
  task automatic test_random_volumes();
    for (int v = 0; v < N_VOLUMES; v++) begin
      steady = (v == STEADY_VOLUME);
      set_dims(VOLUME_DIMS[v][0], VOLUME_DIMS[v][1], VOLUME_DIMS[v][2]);
      while (!volume_filled()) load_sample(rand_sample());
      repeat (RANDOM_BEATS) begin
        if ($urandom_range(0, 99) < QUERY_PCT) begin
          query_voxel(rand_pos(), rand_pos(), rand_pos());
        end else begin
          load_sample(rand_sample());
        end
      end
      settle();
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("ERROR: result %0d %s: got %0d, want %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  // Hold ready low in reset, then stall at random except in the steady run.
  initial begin
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      results.ready <= !rst && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Match each result beat against the oldest queued mean.
  always @(posedge clk) begin : check_results
    mean_t want;
    if (!rst && results.valid && results.ready) begin
      results_seen++;
      if (pending_means.size() == 0) begin
        flag_mismatch("with no query outstanding, smoothed", results.smoothed, 0);
      end else begin
        want = pending_means.pop_front();
        if (results.smoothed !== want.smoothed) begin
          flag_mismatch("smoothed", results.smoothed, want.smoothed);
        end
        if (results.neighbour_count !== want.count) begin
          flag_mismatch("neighbour_count", results.neighbour_count, want.count);
        end
      end
    end
  end

  // Abort when no beat has moved on either channel for too long.
  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("volume_box_filter_3x3x3_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_DIM_X;
    cfg_data     <= '0;
    items.valid  <= 1'b0;
    items.cmd    <= CMD_LOAD;
    items.sample <= '0;
    items.pos_x  <= '0;
    items.pos_y  <= '0;
    items.pos_z  <= '0;
    steady       = 1'b0;
    load_ptr     = 0;
    for (int i = 0; i < 3; i++) dim_reg[i] = DIM_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_truncation();
    test_degenerate_dims();
    test_random_volumes();

    // Each test ends drained; settle once more to catch stray result beats.
    settle();
    if (mismatches == 0) begin
      $display("volume_box_filter_3x3x3_core: match");
    end else begin
      $display("volume_box_filter_3x3x3_core: mismatch");
    end
    $finish;
  end

endmodule
